// ----- src/lgdf_pkg.sv -----
// Shared constants and types of the LED grid decay fader.
// Used by the core, its generic RAM instances' users and the port checker.
// No dependencies.
`default_nettype none

package lgdf_pkg;

    // Grid size and field widths
    localparam int MAX_CELLS = 64;
    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int POS_W     = 6;
    localparam int DIM_W     = 7;
    localparam int LEVEL_W   = 17;
    localparam int FACTOR_W  = 16;
    localparam int PROD_W    = LEVEL_W + FACTOR_W;
    localparam int LIN_W     = POS_W + DIM_W + 1;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    // Level that stands for 1.0
    localparam logic [LEVEL_W-1:0] ONE_LEVEL = LEVEL_W'(65536);

    // Register reset values
    localparam logic [DIM_W-1:0]    RST_GRID_WIDTH   = DIM_W'(8);
    localparam logic [DIM_W-1:0]    RST_GRID_HEIGHT  = DIM_W'(8);
    localparam logic [FACTOR_W-1:0] RST_DECAY_FACTOR = FACTOR_W'(65470);
    localparam logic [LEVEL_W-1:0]  RST_CUTOFF_LEVEL = LEVEL_W'(66);

    // Command codes
    localparam logic CMD_SET_CELL = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH   = 2'd0,
        REG_GRID_HEIGHT  = 2'd1,
        REG_DECAY_FACTOR = 2'd2,
        REG_CUTOFF_LEVEL = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- src/lgdf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lgdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/led_grid_decay_fader_core.sv -----
// Top level of the LED grid decay fader: grid state, tick sequencer and the
// shared multiply/cutoff unit. Depends on lgdf_pkg and lgdf_ram.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-------------------------------
//  input    | in        | in_valid / in_stall  | cmd, col, row, pressed
//  output   | out       | out_valid / out_stall| cell_index, level, last_cell
//  config   | in        | cfg_we               | cfg_index, cfg_data
//
// A set-cell transaction leaves the block idle. A tick on an active grid walks
// its cells in order: for each cell the load state takes the cell RAMs' read
// data and forms the product in the single multiplier, and the finish state
// scales, applies the cutoff, writes back and loads the output register.
// Reset clears all pressed bits and levels through per-entry valid bits, so
// no clearing pass is needed. A stalled output holds the walk in its second
// step; input stays stalled until the last cell's result has been loaded.
`default_nettype none

module led_grid_decay_fader_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              cmd,
    input  wire logic [lgdf_pkg::POS_W-1:0]        col,
    input  wire logic [lgdf_pkg::POS_W-1:0]        row,
    input  wire logic                              pressed,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [lgdf_pkg::IDX_W-1:0]        cell_index,
    output logic      [lgdf_pkg::LEVEL_W-1:0]      level,
    output logic                                   last_cell,
    input  wire logic                              cfg_we,
    input  wire logic [lgdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lgdf_pkg::CFG_W-1:0]        cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [lgdf_pkg::DIM_W-1:0]    grid_width_reg;
    logic [lgdf_pkg::DIM_W-1:0]    grid_height_reg;
    logic [lgdf_pkg::FACTOR_W-1:0] decay_factor_reg;
    logic [lgdf_pkg::LEVEL_W-1:0]  cutoff_level_reg;

    logic [lgdf_pkg::IDX_W-1:0]     cnt_reg, cnt_next;
    logic                           alive_reg, alive_next;
    logic                           active_reg, active_next;
    logic [lgdf_pkg::MAX_CELLS-1:0] prs_valid_reg, prs_valid_next;
    logic [lgdf_pkg::MAX_CELLS-1:0] lvl_valid_reg, lvl_valid_next;
    logic                           out_valid_reg, out_valid_next;
    logic [lgdf_pkg::PROD_W-1:0]    product_reg;
    logic [lgdf_pkg::IDX_W-1:0]     cell_index_reg;
    logic [lgdf_pkg::LEVEL_W-1:0]   level_reg;
    logic                           last_cell_reg;

    logic [2*lgdf_pkg::DIM_W-1:0]  area;
    logic [lgdf_pkg::CNT_W-1:0]    cell_cnt;
    logic [lgdf_pkg::LIN_W-1:0]    lin_idx;
    logic                          write_ok;
    logic                          in_acc;
    logic                          out_free;
    logic                          last_now;

    logic                          prs_we;
    logic                          lvl_we;
    logic                          rd_en;
    logic [lgdf_pkg::IDX_W-1:0]    rd_addr;
    logic [0:0]                    prs_rd;
    logic [lgdf_pkg::LEVEL_W-1:0]  lvl_rd;
    logic                          prs_eff;
    logic [lgdf_pkg::LEVEL_W-1:0]  lvl_eff;
    logic [lgdf_pkg::LEVEL_W-1:0]  lv_in;
    logic [lgdf_pkg::PROD_W-1:0]   product_next;
    logic [lgdf_pkg::LEVEL_W-1:0]  scaled;
    logic [lgdf_pkg::LEVEL_W-1:0]  final_level;

    // Cell count, saturated at the grid capacity
    assign area     = (2*lgdf_pkg::DIM_W)'(grid_width_reg)
                      * (2*lgdf_pkg::DIM_W)'(grid_height_reg);
    assign cell_cnt = (area > (2*lgdf_pkg::DIM_W)'(lgdf_pkg::MAX_CELLS))
                      ? lgdf_pkg::CNT_W'(lgdf_pkg::MAX_CELLS)
                      : area[lgdf_pkg::CNT_W-1:0];

    assign lin_idx  = lgdf_pkg::LIN_W'(row) * lgdf_pkg::LIN_W'(grid_width_reg)
                      + lgdf_pkg::LIN_W'(col);
    assign write_ok = lin_idx < lgdf_pkg::LIN_W'(cell_cnt);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_now  = (lgdf_pkg::CNT_W'(cnt_reg) + lgdf_pkg::CNT_W'(1)) == cell_cnt;

    assign out_valid  = out_valid_reg;
    assign cell_index = cell_index_reg;
    assign level      = level_reg;
    assign last_cell  = last_cell_reg;

    // Cell state: a clear valid bit means the entry still holds its reset value
    assign prs_eff = prs_valid_reg[cnt_reg] && prs_rd[0];
    assign lvl_eff = lvl_valid_reg[cnt_reg] ? lvl_rd : '0;
    assign lv_in   = prs_eff ? lgdf_pkg::ONE_LEVEL : lvl_eff;

    // The single shared multiplier
    assign product_next = lgdf_pkg::PROD_W'(lv_in) * lgdf_pkg::PROD_W'(decay_factor_reg);

    assign scaled      = product_reg[lgdf_pkg::PROD_W-1:lgdf_pkg::FACTOR_W];
    assign final_level = (scaled < cutoff_level_reg) ? '0 : scaled;

    lgdf_ram #(
        .WIDTH (1),
        .DEPTH (lgdf_pkg::MAX_CELLS)
    ) u_pressed_ram (
        .clk     (clk),
        .we      (prs_we),
        .wr_addr (lin_idx[lgdf_pkg::IDX_W-1:0]),
        .wr_data (pressed),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (prs_rd)
    );

    lgdf_ram #(
        .WIDTH (lgdf_pkg::LEVEL_W),
        .DEPTH (lgdf_pkg::MAX_CELLS)
    ) u_level_ram (
        .clk     (clk),
        .we      (lvl_we),
        .wr_addr (cnt_reg),
        .wr_data (final_level),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (lvl_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        alive_next     = alive_reg;
        active_next    = active_reg;
        prs_valid_next = prs_valid_reg;
        lvl_valid_next = lvl_valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        prs_we         = 1'b0;
        lvl_we         = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg + lgdf_pkg::IDX_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (cmd == lgdf_pkg::CMD_SET_CELL)
                    begin
                        if (write_ok)
                        begin
                            prs_we = 1'b1;
                            prs_valid_next[lin_idx[lgdf_pkg::IDX_W-1:0]] = 1'b1;
                            active_next = 1'b1;
                        end
                    end
                    else if (active_reg)
                    begin
                        if (cell_cnt == '0)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            cnt_next   = '0;
                            alive_next = 1'b0;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end

            ST_LOAD:
            begin
                if (prs_eff || (lvl_eff != '0))
                begin
                    alive_next = 1'b1;
                end
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                // Wait here while the previous result is still held
                if (out_free)
                begin
                    lvl_we                  = 1'b1;
                    lvl_valid_next[cnt_reg] = 1'b1;
                    out_valid_next          = 1'b1;
                    if (last_now)
                    begin
                        active_next = alive_reg;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        cnt_next   = cnt_reg + lgdf_pkg::IDX_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            alive_reg     <= 1'b0;
            active_reg    <= 1'b1;
            prs_valid_reg <= '0;
            lvl_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            alive_reg     <= alive_next;
            active_reg    <= active_next;
            prs_valid_reg <= prs_valid_next;
            lvl_valid_reg <= lvl_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= lgdf_pkg::RST_GRID_WIDTH;
            grid_height_reg  <= lgdf_pkg::RST_GRID_HEIGHT;
            decay_factor_reg <= lgdf_pkg::RST_DECAY_FACTOR;
            cutoff_level_reg <= lgdf_pkg::RST_CUTOFF_LEVEL;
        end
        else if (cfg_we)
        begin
            case (lgdf_pkg::cfg_reg_t'(cfg_index))
                lgdf_pkg::REG_GRID_WIDTH:   grid_width_reg   <= cfg_data[lgdf_pkg::DIM_W-1:0];
                lgdf_pkg::REG_GRID_HEIGHT:  grid_height_reg  <= cfg_data[lgdf_pkg::DIM_W-1:0];
                lgdf_pkg::REG_DECAY_FACTOR: decay_factor_reg <= cfg_data[lgdf_pkg::FACTOR_W-1:0];
                lgdf_pkg::REG_CUTOFF_LEVEL: cutoff_level_reg <= cfg_data[lgdf_pkg::LEVEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers carry no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            product_reg <= product_next;
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            cell_index_reg <= cnt_reg;
            level_reg      <= final_level;
            last_cell_reg  <= last_now;
        end
    end

endmodule

`default_nettype wire

// ----- src/lgdf_checker.sv -----
// Port-level checker for the LED grid decay fader core, with its bind.
// Depends on lgdf_pkg and binds into led_grid_decay_fader_core.
`default_nettype none

module lgdf_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            cmd,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [lgdf_pkg::IDX_W-1:0]      cell_index,
    input wire logic [lgdf_pkg::LEVEL_W-1:0]    level,
    input wire logic                            last_cell
);

    // A stalled result is neither dropped nor altered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level) && $stable(cell_index)
                                   && $stable(last_cell))
        else $error("stalled result changed or vanished");

    // Decayed levels never reach 1.0.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level < lgdf_pkg::ONE_LEVEL)
        else $error("level out of range");

    // A set-cell transaction leaves the block ready in the next cycle.
    a_set_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == lgdf_pkg::CMD_SET_CELL) |=> !in_stall)
        else $error("set-cell transaction left the block busy");

    // Once a result other than the last is taken, the tick is still running
    // or its last result is already waiting in the output register.
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_cell |=> in_stall || out_valid)
        else $error("input accepted in the middle of a tick");

endmodule

bind led_grid_decay_fader_core lgdf_checker u_lgdf_checker (.*);

`default_nettype wire

// ----- tb/sv/lgdf_fade_check_pkg.sv -----
// Scoreboard for the LED grid decay fader: keeps its own copy of the grid
// and registers, predicts the per-cell level reports and checks them.
// Depends on lgdf_pkg for widths, command codes and register indexes.
`timescale 1ns / 100ps

package lgdf_fade_check_pkg;

    import lgdf_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [LEVEL_W-1:0] lvl;
        logic               last_flag;
    } cell_report_t;

    class fade_scoreboard;

        logic [DIM_W-1:0]    width_q;
        logic [DIM_W-1:0]    height_q;
        logic [FACTOR_W-1:0] factor_q;
        logic [LEVEL_W-1:0]  cutoff_q;
        bit                  pressed_map [MAX_CELLS];
        logic [LEVEL_W-1:0]  level_map [MAX_CELLS];
        bit                  grid_active;
        cell_report_t        due_reports [$];
        int unsigned         errors;

        function new();
            width_q     = RST_GRID_WIDTH;
            height_q    = RST_GRID_HEIGHT;
            factor_q    = RST_DECAY_FACTOR;
            cutoff_q    = RST_CUTOFF_LEVEL;
            grid_active = 1'b1;
            errors      = 0;
            foreach (pressed_map[i])
            begin
                pressed_map[i] = 1'b0;
                level_map[i]   = '0;
            end
        endfunction

        function void write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
            case (r)
                REG_GRID_WIDTH:   width_q  = v[DIM_W-1:0];
                REG_GRID_HEIGHT:  height_q = v[DIM_W-1:0];
                REG_DECAY_FACTOR: factor_q = v[FACTOR_W-1:0];
                REG_CUTOFF_LEVEL: cutoff_q = v[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned cell_total();
            int unsigned n;
            n = int'(width_q) * int'(height_q);
            return (n > MAX_CELLS) ? MAX_CELLS : n;
        endfunction

        function int unsigned pending();
            return due_reports.size();
        endfunction

        // Advances the grid by one accepted transaction and queues the
        // level reports that a tick produces.
        function void note_input(logic c, logic [POS_W-1:0] cl, logic [POS_W-1:0] rw,
                                 logic p);
            int unsigned       cells;
            int unsigned       lin;
            int unsigned       n;
            longint unsigned   lv;
            bit                alive;
            cell_report_t      rep;
            cells = cell_total();
            if (c == CMD_SET_CELL)
            begin
                lin = int'(rw) * int'(width_q) + int'(cl);
                if (lin < cells)
                begin
                    pressed_map[lin] = p;
                    grid_active      = 1'b1;
                end
                return;
            end
            if (!grid_active)
                return;
            alive = 1'b0;
            for (n = 0; n < cells; n++)
            begin
                lv = level_map[n];
                if (pressed_map[n])
                begin
                    lv    = ONE_LEVEL;
                    alive = 1'b1;
                end
                if (lv != 0)
                begin
                    alive = 1'b1;
                    lv    = (lv * factor_q) >> 16;
                end
                if (lv < cutoff_q)
                    lv = 0;
                level_map[n]  = lv[LEVEL_W-1:0];
                rep.index     = IDX_W'(n);
                rep.lvl       = level_map[n];
                rep.last_flag = (n + 1 == cells);
                due_reports.push_back(rep);
            end
            grid_active = alive;
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [LEVEL_W-1:0] lvl,
                                   logic last_flag);
            cell_report_t want;
            if (due_reports.size() == 0)
            begin
                $error("unexpected level report: cell_index %0d level %0d", idx, lvl);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            if (idx !== want.index)
            begin
                $error("cell_index: expected %0d, actual %0d", want.index, idx);
                errors++;
            end
            if (lvl !== want.lvl)
            begin
                $error("level: expected %0d, actual %0d", want.lvl, lvl);
                errors++;
            end
            if (last_flag !== want.last_flag)
            begin
                $error("last_cell: expected %0d, actual %0d", want.last_flag, last_flag);
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/led_grid_decay_fader_core_test.sv -----
// Top-level test of led_grid_decay_fader_core: directed and random set-cell
// and tick transactions under varying idling, checked by fade_scoreboard.
// Depends on lgdf_pkg and lgdf_fade_check_pkg.
`timescale 1ns / 100ps

module led_grid_decay_fader_core_test;

    import lgdf_pkg::*;
    import lgdf_fade_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    // A full tick walks all 64 cells.
    localparam int unsigned WALK_SLACK  = 2 * MAX_CELLS + 12;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [POS_W-1:0]     col;
    logic [POS_W-1:0]     row;
    logic                 pressed;
    logic                 out_valid;
    logic                 out_stall;
    logic [IDX_W-1:0]     cell_index;
    logic [LEVEL_W-1:0]   level;
    logic                 last_cell;
    logic                 cfg_we;
    cfg_reg_t             cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    fade_scoreboard sb = new();
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    int unsigned    hold_left;
    int unsigned    cycles;

    led_grid_decay_fader_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .col        (col),
        .row        (row),
        .pressed    (pressed),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_index (cell_index),
        .level      (level),
        .last_cell  (last_cell),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off while hold_left counts down.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(cell_index, level, last_cell);
    end

    task automatic send_item(input logic c, input logic [POS_W-1:0] cl,
                             input logic [POS_W-1:0] rw, input logic p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        col      <= cl;
        row      <= rw;
        pressed  <= p;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(c, cl, rw, p);
    endtask

    // Waits for every queued report, then for a walk that emits nothing.
    task automatic wait_drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (WALK_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        sb.write_reg(r, v);
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CFG_W-1:0] f, input logic [CFG_W-1:0] c);
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drain();
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_DECAY_FACTOR, f);
        write_reg(REG_CUTOFF_LEVEL, c);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly small grids, with the occasional wide, tall or empty one.
    task automatic random_grid();
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] f;
        logic [CFG_W-1:0] c;
        w = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(127))
                                     : CFG_W'($urandom_range(1, 8));
        h = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(127))
                                     : CFG_W'($urandom_range(1, 8));
        case ($urandom_range(7))
            0:       f = 65535;
            1:       f = CFG_W'($urandom_range(65535));
            default: f = CFG_W'($urandom_range(30000, 65000));
        endcase
        case ($urandom_range(7))
            0:       c = 0;
            1:       c = 65536;
            2:       c = CFG_W'($urandom_range(131071));
            default: c = CFG_W'($urandom_range(1, 3000));
        endcase
        set_grid(w, h, f, c);
    endtask

    // Presses and releases of cells inside the grid mixed with ticks, plus
    // noise that may land outside the grid and does not count.
    task automatic fade_burst(input int unsigned items);
        int unsigned      done_cnt;
        int unsigned      cells;
        int unsigned      lin;
        int unsigned      pick;
        int unsigned      w;
        done_cnt = 0;
        while (done_cnt < items)
        begin
            cells = sb.cell_total();
            w     = sb.width_q;
            pick  = $urandom_range(99);
            if (pick < 45 && cells > 0)
            begin
                lin = $urandom_range(cells - 1);
                send_item(CMD_SET_CELL, POS_W'(lin % w), POS_W'(lin / w),
                          $urandom_range(99) < 60);
                done_cnt++;
            end
            else if (pick < 80)
            begin
                send_item(CMD_TICK, POS_W'($urandom_range(63)),
                          POS_W'($urandom_range(63)), 1'($urandom_range(1)));
                done_cnt++;
            end
            else
                send_item(1'($urandom_range(1)), POS_W'($urandom_range(63)),
                          POS_W'($urandom_range(63)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = CMD_SET_CELL;
        col           = '0;
        row           = '0;
        pressed       = 1'b0;
        out_stall     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_GRID_WIDTH;
        cfg_data      = '0;
        cycles        = 0;
        hold_left     = 0;
        send_idle_pct = 23;
        recv_idle_pct = 65;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset grid: the first tick reports all zeros and goes idle.
        send_item(CMD_TICK, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0);
        send_item(CMD_SET_CELL, 63, 63, 1'b1);
        send_item(CMD_TICK, 0, 0, 0);
        send_item(CMD_SET_CELL, 63, 0, 1'b1);
        send_item(CMD_SET_CELL, 0, 0, 1'b1);
        send_item(CMD_TICK, 0, 0, 0);
        send_item(CMD_SET_CELL, 0, 0, 1'b0);
        send_item(CMD_TICK, 63, 63, 1'b1);

        // Widest row: the second row lies beyond the saturated cell count.
        set_grid(127, 1, 65535, 0);
        send_item(CMD_SET_CELL, 0, 1, 1'b1);
        send_item(CMD_SET_CELL, 5, 0, 1'b1);
        send_item(CMD_TICK, 0, 0, 0);

        // Zero factor and a cutoff above one: every level collapses.
        set_grid(64, 64, 0, 131071);
        send_item(CMD_TICK, 0, 0, 0);
        send_item(CMD_SET_CELL, 63, 0, 1'b0);
        send_item(CMD_SET_CELL, 0, 0, 1'b0);
        send_item(CMD_SET_CELL, 5, 0, 1'b0);
        send_item(CMD_TICK, 0, 0, 0);
        send_item(CMD_SET_CELL, 1, 0, 1'b1);

        // An active tick on an empty grid emits nothing and goes idle.
        set_grid(0, 5, 30000, 65536);
        send_item(CMD_TICK, 0, 0, 0);
        set_grid(2, 2, 65535, 65536);
        send_item(CMD_TICK, 0, 0, 0);
        send_item(CMD_SET_CELL, 1, 1, 1'b1);
        send_item(CMD_TICK, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0);

        repeat (3)
        begin
            random_grid();
            fade_burst(18);
        end

        send_idle_pct = 65;
        recv_idle_pct = 23;
        repeat (3)
        begin
            random_grid();
            fade_burst(18);
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_grid(8, 8, 60000, 500);
        send_item(CMD_SET_CELL, 3, 2, 1'b1);
        // The receiver holds off while ticks queue up behind the walk.
        hold_left = 300;
        fade_burst(18);
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drain();
        fade_burst(18);
        random_grid();
        fade_burst(18);

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drain();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
